// ----- rtl/graph_coloring_enumerator_assert.svh -----
// assertion macros for the graph coloring enumerator
`ifndef GRAPH_COLORING_ENUMERATOR_ASSERT_SVH
`define GRAPH_COLORING_ENUMERATOR_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define GCE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("graph coloring enumerator check failed");
// next-cycle implication
`define GCE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("graph coloring enumerator check failed");
`else
`define GCE_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define GCE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/gce_pkg.sv -----
package gce_pkg;

   localparam int MAX_REGIONS_DEF = 16;
   localparam int MAX_COLORS_DEF  = 4;

   localparam int ROW_INDEX_W   = 4;
   localparam int ROW_W         = 16;
   localparam int COLORING_W    = 32;
   localparam int COUNT_W       = 32;
   localparam int NUM_REGIONS_W = 5;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   // item modes
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_NEXT = 1'b1;

   // register index, taken from paddr[2]
   localparam logic REG_NUM_REGIONS = 1'b0;

   typedef struct packed {
      logic                   mode;
      logic [ROW_INDEX_W-1:0] row_index;
      logic [ROW_W-1:0]       row_bits;
   } req_payload_type;

   typedef struct packed {
      logic                  found;
      logic [COLORING_W-1:0] coloring;
      logic [COUNT_W-1:0]    solution_number;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } search_status_type;

   typedef enum logic [1:0] {
      SQ_IDLE,
      SQ_STEP,
      SQ_HOLD
   } seq_state_type;

   // top level to search sequencer
   typedef struct packed {
      logic                   start;
      logic                   restart;
      logic                   load;
      logic [ROW_INDEX_W-1:0] load_index;
      logic [ROW_W-1:0]       load_row;
      logic                   take;
   } search_ctrl_type;

   // search sequencer to top level
   typedef struct packed {
      logic busy;
      logic hold;
   } search_stat_type;

endpackage

// ----- rtl/graph_coloring_enumerator.sv -----
// enumerates every proper coloring of a graph of up to MaxRegions regions with up to
// MaxColors colors, in lexicographic order with region 0 most significant. write the
// adjacency with load items (mode 0, one row each, no result), then send next items
// (mode 1): each returns the next coloring with its running solution number, or, once the
// search is exhausted, found = 0 with the final count, repeated until a restart. a load
// item or a write to num_regions (byte address 0) restarts the search from the first
// coloring. a next item starts the search, which then takes one search step at a time,
// where a step either places a color on one region or backtracks out of it, and then
// hands the result to the output register once that is free; the step count depends
// on the graph and is bounded by the size of the search tree. the single color-fit
// unit checks one region against all its bordering regions combinationally. no input
// item is taken while a search is running or its result waits. the adjacency store
// is cleared by reset directly, so the block is ready in the cycle after reset.
module graph_coloring_enumerator import gce_pkg::*; #(
   parameter int MaxRegions = MAX_REGIONS_DEF,
   parameter int MaxColors  = MAX_COLORS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,

   // input item channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_payload,

   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_payload,

   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [NUM_REGIONS_W-1:0] num_regions_ff, num_regions_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_payload_type          rsp_payload_ff, rsp_payload_in;

   logic                     req_accept;
   logic                     cfg_write;
   logic                     out_free;
   search_ctrl_type          ctrl;
   search_stat_type          stat;
   rsp_payload_type          result;

   // register port: always ready, register index in paddr[2]
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == REG_NUM_REGIONS);

   always_comb begin
      if (csr_paddr[2] == REG_NUM_REGIONS) begin
         csr_prdata = CSR_DATA_W'(num_regions_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   assign num_regions_in = cfg_write ? csr_pwdata[NUM_REGIONS_W-1:0] : num_regions_ff;

   // input side: items are taken only while no search is running
   assign req_stall  = stat.busy;
   assign req_accept = req_valid && !req_stall;

   // output register frees up when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      ctrl.start      = req_accept && (req_payload.mode == MODE_NEXT);
      ctrl.load       = req_accept && (req_payload.mode == MODE_LOAD);
      ctrl.load_index = req_payload.row_index;
      ctrl.load_row   = req_payload.row_bits;
      // a load item and a region count write both restart the search
      ctrl.restart    = ctrl.load || cfg_write;
      ctrl.take       = stat.hold && out_free;
   end

   gce_search #(
      .MaxRegions (MaxRegions),
      .MaxColors  (MaxColors)
   ) u_search (
      .clock       (clock),
      .reset       (reset),
      .num_regions (num_regions_ff),
      .ctrl        (ctrl),
      .stat        (stat),
      .result      (result)
   );

   // result register
   always_comb begin
      rsp_payload_in = rsp_payload_ff;
      if (ctrl.take) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = result;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_regions_ff <= NUM_REGIONS_W'(1);
         rsp_valid_ff   <= 1'b0;
      end else begin
         num_regions_ff <= num_regions_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ----- rtl/gce_fit_unit.sv -----
module gce_fit_unit import gce_pkg::*; #(
   parameter int MaxRegions = MAX_REGIONS_DEF,
   parameter int MaxColors  = MAX_COLORS_DEF,
   localparam int RegW   = $clog2(MaxRegions),
   localparam int ColorW = $clog2(MaxColors + 1)
) (
   input  logic [MaxRegions-1:0][ColorW-1:0] colors,
   input  logic [MaxRegions-1:0]             row,
   input  logic [RegW-1:0]                   region,
   input  logic [ColorW-1:0]                 cur_color,
   output logic                              fit_ok,
   output logic [ColorW-1:0]                 fit_color
);

   logic [MaxColors:1] forbidden;

   // colors held by bordering regions, self loop ignored
   always_comb begin
      forbidden = '0;
      for (int c = 1; c <= MaxColors; c++) begin
         for (int j = 0; j < MaxRegions; j++) begin
            if (row[j] && (RegW'(j) != region) && (colors[j] == ColorW'(c))) begin
               forbidden[c] = 1'b1;
            end
         end
      end
   end

   // lowest allowed color above the current one
   always_comb begin
      fit_ok    = 1'b0;
      fit_color = '0;
      for (int c = MaxColors; c >= 1; c--) begin
         if ((ColorW'(c) > cur_color) && !forbidden[c]) begin
            fit_ok    = 1'b1;
            fit_color = ColorW'(c);
         end
      end
   end

endmodule

// ----- rtl/gce_search.sv -----
`include "graph_coloring_enumerator_assert.svh"

module gce_search import gce_pkg::*; #(
   parameter int MaxRegions = MAX_REGIONS_DEF,
   parameter int MaxColors  = MAX_COLORS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [NUM_REGIONS_W-1:0] num_regions,
   input  search_ctrl_type          ctrl,
   output search_stat_type          stat,
   output rsp_payload_type          result
);

   localparam int RegW   = $clog2(MaxRegions);
   localparam int CntW   = $clog2(MaxRegions + 1);
   localparam int ColorW = $clog2(MaxColors + 1);

   logic [MaxRegions-1:0][MaxRegions-1:0] adj_ff, adj_in;
   logic [MaxRegions-1:0][ColorW-1:0]     color_ff, color_in;
   logic [RegW-1:0]                       r_ff, r_in;
   logic [COUNT_W-1:0]                    sol_ff, sol_in;
   search_status_type                     status_ff, status_in;
   seq_state_type                         state_ff, state_in;

   logic [CntW-1:0]                       n;
   logic [MaxRegions-1:0]                 active_mask;
   logic [MaxRegions-1:0]                 row;
   logic                                  fit_ok;
   logic [ColorW-1:0]                     fit_color;
   logic [MaxRegions-1:0][ColorW-1:0]     color_less;

   // clipped region count
   always_comb begin
      if (num_regions == '0) begin
         n = CntW'(1);
      end else if (num_regions > NUM_REGIONS_W'(MaxRegions)) begin
         n = CntW'(MaxRegions);
      end else begin
         n = num_regions[CntW-1:0];
      end
   end

   always_comb begin
      for (int j = 0; j < MaxRegions; j++) begin
         active_mask[j] = (CntW'(j) < n);
      end
   end

   assign row = adj_ff[r_ff] & active_mask;

   gce_fit_unit #(
      .MaxRegions (MaxRegions),
      .MaxColors  (MaxColors)
   ) u_fit (
      .colors    (color_ff),
      .row       (row),
      .region    (r_ff),
      .cur_color (color_ff[r_ff]),
      .fit_ok    (fit_ok),
      .fit_color (fit_color)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         adj_ff    <= '0;
         color_ff  <= '0;
         r_ff      <= '0;
         sol_ff    <= '0;
         status_ff <= ST_IDLE;
         state_ff  <= SQ_IDLE;
      end else begin
         adj_ff    <= adj_in;
         color_ff  <= color_in;
         r_ff      <= r_in;
         sol_ff    <= sol_in;
         status_ff <= status_in;
         state_ff  <= state_in;
      end
   end

   always_comb begin
      adj_in    = adj_ff;
      color_in  = color_ff;
      r_in      = r_ff;
      sol_in    = sol_ff;
      status_in = status_ff;
      state_in  = state_ff;

      if (ctrl.restart) begin
         if (ctrl.load && ({1'b0, ctrl.load_index} < (ROW_INDEX_W + 1)'(MaxRegions))) begin
            adj_in[ctrl.load_index[RegW-1:0]] = ctrl.load_row[MaxRegions-1:0];
         end
         color_in  = '0;
         r_in      = '0;
         sol_in    = '0;
         status_in = ST_IDLE;
         state_in  = SQ_IDLE;
      end else begin
         unique case (state_ff)
            SQ_IDLE: begin
               if (ctrl.start) begin
                  unique case (status_ff)
                     ST_DONE: begin
                        state_in = SQ_HOLD;
                     end
                     ST_IDLE: begin
                        color_in = '0;
                        r_in     = '0;
                        state_in = SQ_STEP;
                     end
                     default: begin
                        // resume from the last region of the previous coloring
                        r_in     = RegW'(n - CntW'(1));
                        state_in = SQ_STEP;
                     end
                  endcase
               end
            end
            SQ_STEP: begin
               if (fit_ok) begin
                  color_in[r_ff] = fit_color;
                  if ((CntW'(r_ff) + CntW'(1)) == n) begin
                     if (sol_ff != '1) begin
                        sol_in = sol_ff + COUNT_W'(1);
                     end
                     status_in = ST_RUN;
                     state_in  = SQ_HOLD;
                  end else begin
                     r_in                        = r_ff + RegW'(1);
                     color_in[r_ff + RegW'(1)]   = '0;
                  end
               end else begin
                  color_in[r_ff] = '0;
                  if (r_ff == '0) begin
                     status_in = ST_DONE;
                     state_in  = SQ_HOLD;
                  end else begin
                     r_in = r_ff - RegW'(1);
                  end
               end
            end
            SQ_HOLD: begin
               if (ctrl.take) begin
                  state_in = SQ_IDLE;
               end
            end
            default: begin
               state_in = SQ_IDLE;
            end
         endcase
      end
   end

   assign stat.busy = (state_ff != SQ_IDLE);
   assign stat.hold = (state_ff == SQ_HOLD);

   // two bits per region, color minus one
   always_comb begin
      result.found           = (status_ff == ST_RUN);
      result.coloring        = '0;
      result.solution_number = sol_ff;
      for (int k = 0; k < MaxRegions; k++) begin
         color_less[k] = color_ff[k] - ColorW'(1);
         if (result.found && active_mask[k]) begin
            result.coloring[2*k +: 2] = 2'(color_less[k]);
         end
      end
   end

   `GCE_ASSERT_IMPLY(a_step_region_in_range, clock, reset,
      state_ff == SQ_STEP, CntW'(r_ff) < n)
   `GCE_ASSERT_IMPLY(a_found_is_counted, clock, reset,
      (state_ff == SQ_HOLD) && (status_ff == ST_RUN), sol_ff != '0)
   `GCE_ASSERT_NEXT(a_exhausted_answers_at_once, clock, reset,
      (state_ff == SQ_IDLE) && ctrl.start && !ctrl.restart && (status_ff == ST_DONE),
      state_ff == SQ_HOLD)
   `GCE_ASSERT_NEXT(a_restart_clears_search, clock, reset, ctrl.restart,
      (sol_ff == '0) && (status_ff == ST_IDLE) && (state_ff == SQ_IDLE))

endmodule
